/* hdl/fcull_pkg.sv */
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared types, constants and helpers for the six-plane frustum cull test.
// ----------------------------------------------------------------------------
`default_nettype none

package fcull_pkg;

	// coordinate format: signed Q15.8 at the default width
	localparam int COORD_BITS = 24;
	localparam int SIZE_BITS  = COORD_BITS - 1;

	// plane register packing
	localparam int NUM_PLANES = 6;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int COEF_BITS  = 12;
	localparam int OFFS_BITS  = 28;
	localparam int COEF_FRAC  = 10;

	// arithmetic widths
	localparam int PROD_W = COORD_BITS + COEF_BITS;
	localparam int DTRM_W = OFFS_BITS + COEF_FRAC;
	localparam int BIAS_W = SIZE_BITS + COEF_FRAC;
	localparam int SUM_W  = ((PROD_W > DTRM_W) ? PROD_W : DTRM_W) + 3;

	typedef enum logic [1:0] {
		OP_POINT  = 2'd0,
		OP_CUBE   = 2'd1,
		OP_SPHERE = 2'd2,
		OP_BOX    = 2'd3
	} op_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] a;
		logic signed [COEF_BITS-1:0] b;
		logic signed [COEF_BITS-1:0] c;
		logic signed [OFFS_BITS-1:0] d;
	} plane_t;

	// upper and lower coordinate per axis; the plane picks one of each
	typedef struct packed {
		logic signed [COORD_BITS-1:0] hi_x;
		logic signed [COORD_BITS-1:0] hi_y;
		logic signed [COORD_BITS-1:0] hi_z;
		logic signed [COORD_BITS-1:0] lo_x;
		logic signed [COORD_BITS-1:0] lo_y;
		logic signed [COORD_BITS-1:0] lo_z;
	} cand_t;

	function automatic plane_t unpack_plane(input logic [CFG_W-1:0] r);
		plane_t p;
		p.a = r[COEF_BITS-1:0];
		p.b = r[2*COEF_BITS-1:COEF_BITS];
		p.c = r[3*COEF_BITS-1:2*COEF_BITS];
		p.d = r[3*COEF_BITS+OFFS_BITS-1:3*COEF_BITS];
		return p;
	endfunction

	// clamp a one-bit-wider sum back into the coordinate range
	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [COORD_BITS:0] v
	);
		logic signed [COORD_BITS-1:0] r;
		if (v[COORD_BITS] != v[COORD_BITS-1]) begin
			r = v[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
			                  : {1'b0, {(COORD_BITS-1){1'b1}}};
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/fcull_plane.sv */
// ----------------------------------------------------------------------------
// fcull_plane
// One plane lane: picks the corner farthest along the plane normal, forms
// the exact signed distance plus bias over two stages, and flags >= 0.
// ----------------------------------------------------------------------------
`default_nettype none

module fcull_plane
	import fcull_pkg::*;
(
	input  wire logic               clk,
	input  wire plane_t             plane,
	input  wire cand_t              cand_s1,
	input  wire logic [BIAS_W-1:0]  bias_s2,
	output logic                    pass_s3
);

	logic signed [COORD_BITS-1:0] sel_x, sel_y, sel_z;
	logic signed [PROD_W-1:0]     prod_x_s2, prod_y_s2, prod_z_s2;
	logic signed [DTRM_W-1:0]     dterm;
	logic signed [SUM_W-1:0]      sum;

	// negative coefficient: the lower coordinate maximizes that term
	assign sel_x = plane.a[COEF_BITS-1] ? cand_s1.lo_x : cand_s1.hi_x;
	assign sel_y = plane.b[COEF_BITS-1] ? cand_s1.lo_y : cand_s1.hi_y;
	assign sel_z = plane.c[COEF_BITS-1] ? cand_s1.lo_z : cand_s1.hi_z;

	// stage 2: products
	always_ff @(posedge clk) begin
		prod_x_s2 <= PROD_W'(plane.a * sel_x);
		prod_y_s2 <= PROD_W'(plane.b * sel_y);
		prod_z_s2 <= PROD_W'(plane.c * sel_z);
	end

	// stage 3: sum with offset and bias, keep the sign
	assign dterm = {plane.d, {COEF_FRAC{1'b0}}};
	assign sum = SUM_W'(prod_x_s2) + SUM_W'(prod_y_s2) + SUM_W'(prod_z_s2)
	           + SUM_W'(dterm) + $signed(SUM_W'(bias_s2));

	always_ff @(posedge clk) begin
		pass_s3 <= ~sum[SUM_W-1];
	end

endmodule

`default_nettype wire

/* hdl/frustum_cull_test_core.sv */
// ----------------------------------------------------------------------------
// frustum_cull_test_core
// Six-plane visibility test for points, spheres, cubes and boxes.
// ----------------------------------------------------------------------------
//  channel   signals                               direction  handshake
//  command   start, busy, op, pos_*, size_*        in         start & !busy
//  result    done, visible                         out        done, one cycle
//  config    cfg_we, cfg_addr, cfg_wdata           in         cfg_we
//
//  One beat per cycle; busy is always low, the pipeline never stalls.
//  Stages in order: corner saturation, products, plane sums,
//  plane combine. Every stage is a plain register with no feedback.
//  Reset clears valid bits and zeroes all planes (every object visible).
//  The receiver cannot stall; done marks each result for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_cull_test_core
	import fcull_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   op,
	input  wire logic signed [COORD_BITS-1:0] pos_x,
	input  wire logic signed [COORD_BITS-1:0] pos_y,
	input  wire logic signed [COORD_BITS-1:0] pos_z,
	input  wire logic [SIZE_BITS-1:0]         size_x,
	input  wire logic [SIZE_BITS-1:0]         size_y,
	input  wire logic [SIZE_BITS-1:0]         size_z,
	output logic                              done,
	output logic                              visible,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_W-1:0]         cfg_addr,
	input  wire logic [CFG_W-1:0]             cfg_wdata
);

	logic [CFG_W-1:0]     plane_q [NUM_PLANES];
	logic                 accept;
	logic                 valid_s1, valid_s2, valid_s3;
	logic                 done_q, visible_q;
	op_t                  op_s1;
	logic [SIZE_BITS-1:0] sx_s1;
	cand_t                cand, cand_s1;
	logic [SIZE_BITS-1:0] ey, ez;
	logic [BIAS_W-1:0]    bias_s2;
	logic [NUM_PLANES-1:0] pass_s3;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// plane registers; out-of-range index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) plane_q[i] <= '0;
		end else if (cfg_we && (cfg_addr < CFG_IDX_W'(NUM_PLANES))) begin
			plane_q[cfg_addr] <= cfg_wdata;
		end
	end

	// valid bits travel with the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	// stage 1: saturated corner coordinates for cubes and boxes, the centre for points and spheres
	always_comb begin
		unique case (op_t'(op))
			OP_BOX: begin
				ey = size_y;
				ez = size_z;
			end
			OP_POINT, OP_CUBE, OP_SPHERE: begin
				ey = size_x;
				ez = size_x;
			end
			default: begin
				ey = size_x;
				ez = size_x;
			end
		endcase
		if (op_t'(op) == OP_CUBE || op_t'(op) == OP_BOX) begin
			cand.hi_x = sat_coord({pos_x[COORD_BITS-1], pos_x} + {2'b00, size_x});
			cand.lo_x = sat_coord({pos_x[COORD_BITS-1], pos_x} - {2'b00, size_x});
			cand.hi_y = sat_coord({pos_y[COORD_BITS-1], pos_y} + {2'b00, ey});
			cand.lo_y = sat_coord({pos_y[COORD_BITS-1], pos_y} - {2'b00, ey});
			cand.hi_z = sat_coord({pos_z[COORD_BITS-1], pos_z} + {2'b00, ez});
			cand.lo_z = sat_coord({pos_z[COORD_BITS-1], pos_z} - {2'b00, ez});
		end else begin
			cand.hi_x = pos_x;
			cand.lo_x = pos_x;
			cand.hi_y = pos_y;
			cand.lo_y = pos_y;
			cand.hi_z = pos_z;
			cand.lo_z = pos_z;
		end
	end

	always_ff @(posedge clk) begin
		cand_s1 <= cand;
		op_s1   <= op_t'(op);
		sx_s1   <= size_x;
	end

	// stage 2: sphere bias is radius scaled to distance format
	always_ff @(posedge clk) begin
		bias_s2 <= (op_s1 == OP_SPHERE) ? {sx_s1, {COEF_FRAC{1'b0}}} : '0;
	end

	// plane lanes
	for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
		fcull_plane u_plane (
			.clk     (clk),
			.plane   (unpack_plane(plane_q[g])),
			.cand_s1 (cand_s1),
			.bias_s2 (bias_s2),
			.pass_s3 (pass_s3[g])
		);
	end

	// stage 4: all planes must pass
	always_ff @(posedge clk) begin
		visible_q <= valid_s3 & (&pass_s3);
	end

	assign done    = done_q;
	assign visible = visible_q & done_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted beat did not produce a result after four cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s2, 2))
		else $error("result without a matching beat in flight");

	a_vis_qual: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !visible)
		else $error("visible high outside a result cycle");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(start))
		else $error("stage 1 valid without a command beat");
`endif

endmodule

`default_nettype wire

/* sim/tb_frustum_cull_test_core.sv */
// ----------------------------------------------------------------------------
// tb_frustum_cull_test_core
// Self-checking bench for the six-plane cull test. It loads plane sets
// (cleared, axis-aligned box, slanted frustum, extreme and raw random words)
// and sends point, cube, sphere and box commands with random gaps. An
// in-bench predictor computes each visible bit, which is checked in order.
// ----------------------------------------------------------------------------
module tb_frustum_cull_test_core;
	timeunit 1ns;
	timeprecision 1ps;

	import fcull_pkg::*;

	localparam int     LATENCY     = 4;
	localparam int     MAX_GAP     = 11;
	localparam int     STALL_LIMIT = 500;
	localparam int     N_RANDOM    = 1250;
	localparam int     N_REPORT    = 10;
	localparam int     COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
	localparam int     COORD_MIN   = -COORD_MAX - 1;
	localparam int     SIZE_MAX    = (1 << SIZE_BITS) - 1;
	localparam int     ONE_Q10     = 1 << COEF_FRAC;   // 1.0 as a plane coefficient

	typedef enum int {SET_ZERO, SET_AXIS, SET_SLANT, SET_EXTREME, SET_RANDOM} plane_set_e;
	localparam int N_SET_KINDS = 5;

	typedef struct {
		op_t                          op;
		logic signed [COORD_BITS-1:0] px, py, pz;
		logic [SIZE_BITS-1:0]         sx, sy, sz;
	} cull_cmd_t;

	// visibility predictor plus in-order store of expected visible bits
	class cull_scoreboard;
		cull_cmd_t        sent_cmd[$];
		bit               want_vis[$];
		logic [CFG_W-1:0] plane_reg[NUM_PLANES] = '{default: '0};
		int               n_op[4];
		int               n_visible, n_checked, n_errors;

		function void set_plane(int idx, logic [CFG_W-1:0] val);
			if (idx < NUM_PLANES) plane_reg[idx] = val;
		endfunction

		// signed distance, 18 fraction bits, no rounding
		function longint plane_dist(int i, longint x, longint y, longint z);
			logic signed [COEF_BITS-1:0] a, b, c;
			logic signed [OFFS_BITS-1:0] d;
			a = plane_reg[i][COEF_BITS-1:0];
			b = plane_reg[i][2*COEF_BITS-1:COEF_BITS];
			c = plane_reg[i][3*COEF_BITS-1:2*COEF_BITS];
			d = plane_reg[i][3*COEF_BITS+OFFS_BITS-1:3*COEF_BITS];
			return longint'(a) * x + longint'(b) * y + longint'(c) * z
				+ longint'(d) * longint'(ONE_Q10);
		endfunction

		function longint clamp_coord(longint v);
			if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
			if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
			return v;
		endfunction

		// every plane needs one corner on its inner side
		function bit box_passes(longint cx, longint cy, longint cz,
			longint sx, longint sy, longint sz);
			longint x, y, z;
			bit     hit;
			for (int i = 0; i < NUM_PLANES; i++) begin
				hit = 1'b0;
				for (int k = 0; k < 8; k++) begin
					x = clamp_coord(k[0] ? cx + sx : cx - sx);
					y = clamp_coord(k[1] ? cy + sy : cy - sy);
					z = clamp_coord(k[2] ? cz + sz : cz - sz);
					if (plane_dist(i, x, y, z) >= 0) hit = 1'b1;
				end
				if (!hit) return 1'b0;
			end
			return 1'b1;
		endfunction

		function bit predict_visible(cull_cmd_t c);
			longint px, py, pz, sx, sy, sz, lim;
			bit     vis;
			px  = longint'(c.px);
			py  = longint'(c.py);
			pz  = longint'(c.pz);
			sx  = longint'(c.sx);
			sy  = longint'(c.sy);
			sz  = longint'(c.sz);
			vis = 1'b1;
			case (c.op)
				OP_POINT: begin
					for (int i = 0; i < NUM_PLANES; i++)
						if (plane_dist(i, px, py, pz) < 0) vis = 1'b0;
				end
				OP_SPHERE: begin
					lim = -(sx * longint'(ONE_Q10));
					for (int i = 0; i < NUM_PLANES; i++)
						if (plane_dist(i, px, py, pz) < lim) vis = 1'b0;
				end
				OP_CUBE: vis = box_passes(px, py, pz, sx, sx, sx);
				default: vis = box_passes(px, py, pz, sx, sy, sz);
			endcase
			return vis;
		endfunction

		function void note_cmd(cull_cmd_t c);
			bit vis;
			vis = predict_visible(c);
			sent_cmd.push_back(c);
			want_vis.push_back(vis);
			n_op[int'(c.op)]++;
			if (vis) n_visible++;
		endfunction

		function void check_result(logic got);
			cull_cmd_t c;
			bit        want;
			if (want_vis.size() == 0) begin
				n_errors++;
				if (n_errors <= N_REPORT)
					$display("result beat with nothing outstanding: visible=%b", got);
				return;
			end
			c    = sent_cmd.pop_front();
			want = want_vis.pop_front();
			n_checked++;
			if (got !== want) begin
				n_errors++;
				if (n_errors <= N_REPORT)
					$display("visible mismatch: %s pos (%0d,%0d,%0d) size (%0d,%0d,%0d)",
						c.op.name(), c.px, c.py, c.pz, c.sx, c.sy, c.sz,
						" exp %b got %b", want, got);
			end
		endfunction

		function int outstanding();
			return want_vis.size();
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [1:0]                   op;
	logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_z;
	logic [SIZE_BITS-1:0]         size_x, size_y, size_z;
	logic                         done;
	logic                         visible;
	logic                         cfg_we;
	logic [CFG_IDX_W-1:0]         cfg_addr;
	logic [CFG_W-1:0]             cfg_wdata;

	logic [CFG_W-1:0] plane_set[NUM_PLANES];
	cull_scoreboard   sb;
	int               stall_cycles = 0;
	int               n_sets = 0;

	frustum_cull_test_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.size_x    (size_x),
		.size_y    (size_y),
		.size_z    (size_z),
		.done      (done),
		.visible   (visible),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result checking and stall watchdog
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(visible);
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [CFG_W-1:0] pack_plane(int a, int b, int c, int d);
		logic [CFG_W-1:0] r;
		r = '0;
		r[COEF_BITS-1:0]                       = a[COEF_BITS-1:0];
		r[2*COEF_BITS-1:COEF_BITS]             = b[COEF_BITS-1:0];
		r[3*COEF_BITS-1:2*COEF_BITS]           = c[COEF_BITS-1:0];
		r[3*COEF_BITS+OFFS_BITS-1:3*COEF_BITS] = d[OFFS_BITS-1:0];
		return r;
	endfunction

	// cube |x|,|y|,|z| <= half
	function automatic void axis_planes(int half);
		plane_set[0] = pack_plane(0, 0, ONE_Q10, half);
		plane_set[1] = pack_plane(0, 0, -ONE_Q10, half);
		plane_set[2] = pack_plane(ONE_Q10, 0, 0, half);
		plane_set[3] = pack_plane(-ONE_Q10, 0, 0, half);
		plane_set[4] = pack_plane(0, -ONE_Q10, 0, half);
		plane_set[5] = pack_plane(0, ONE_Q10, 0, half);
	endfunction

	// fills plane_set, returns a coordinate span that keeps objects near it
	function automatic int build_planes(plane_set_e kind);
		int ext_coef[5] = '{-2048, 2047, 0, 1, -1};
		int ext_offs[4] = '{-(1 << (OFFS_BITS - 1)), (1 << (OFFS_BITS - 1)) - 1, 0, -1};
		int span, k;
		span = $urandom_range(64, 1 << 20);
		case (kind)
			SET_ZERO: begin
				foreach (plane_set[i]) plane_set[i] = '0;
			end
			SET_AXIS: axis_planes(span * 2 / 3);
			SET_SLANT: begin
				// apex at origin looking down +z
				k = $urandom_range(256, 2047);
				plane_set[0] = pack_plane(0, 0, ONE_Q10, -(span / 16));
				plane_set[1] = pack_plane(0, 0, -ONE_Q10, span);
				plane_set[2] = pack_plane(ONE_Q10, 0, k, 0);
				plane_set[3] = pack_plane(-ONE_Q10, 0, k, 0);
				plane_set[4] = pack_plane(0, -ONE_Q10, k, 0);
				plane_set[5] = pack_plane(0, ONE_Q10, k, 0);
			end
			SET_EXTREME: begin
				foreach (plane_set[i])
					plane_set[i] = pack_plane(ext_coef[$urandom_range(0, 4)],
						ext_coef[$urandom_range(0, 4)], ext_coef[$urandom_range(0, 4)],
						ext_offs[$urandom_range(0, 3)]);
				if ($urandom_range(0, 1)) plane_set[$urandom_range(0, NUM_PLANES - 1)] = '1;
				span = COORD_MAX;
			end
			default: begin
				foreach (plane_set[i]) plane_set[i] = {$urandom, $urandom};
				span = COORD_MAX;
			end
		endcase
		return span;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] rand_coord(int span);
		int v;
		v = int'($urandom_range(0, 2 * span)) - span;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic cull_cmd_t gen_cmd(int span);
		cull_cmd_t c;
		int        pick;
		pick = $urandom_range(0, 99);
		c.op = op_t'($urandom_range(0, 3));
		if (pick < 10) begin
			// raw bits over the full field range
			c.px = COORD_BITS'($urandom);
			c.py = COORD_BITS'($urandom);
			c.pz = COORD_BITS'($urandom);
			c.sx = SIZE_BITS'($urandom);
			c.sy = SIZE_BITS'($urandom);
			c.sz = SIZE_BITS'($urandom);
		end else if (pick < 16) begin
			c.px = COORD_BITS'($urandom_range(0, 1) ? COORD_MAX : COORD_MIN);
			c.py = COORD_BITS'($urandom_range(0, 1) ? COORD_MAX : COORD_MIN);
			c.pz = COORD_BITS'($urandom_range(0, 1) ? COORD_MAX : COORD_MIN);
			c.sx = SIZE_BITS'($urandom_range(0, 1) ? SIZE_MAX : 0);
			c.sy = SIZE_BITS'($urandom_range(0, 1) ? SIZE_MAX : 0);
			c.sz = SIZE_BITS'($urandom_range(0, 1) ? SIZE_MAX : 0);
		end else begin
			c.px = rand_coord(span);
			c.py = rand_coord(span);
			c.pz = rand_coord(span);
			c.sx = SIZE_BITS'($urandom_range(0, span / 2));
			c.sy = SIZE_BITS'($urandom_range(0, span / 2));
			c.sz = SIZE_BITS'($urandom_range(0, span / 2));
		end
		return c;
	endfunction

	// six plane writes plus one to an unused index, at a random slot
	task automatic program_planes();
		int               junk_at, idx;
		logic [CFG_W-1:0] val;
		junk_at = $urandom_range(0, NUM_PLANES);
		for (int j = 0; j <= NUM_PLANES; j++) begin
			if (j == junk_at) idx = NUM_PLANES + $urandom_range(0, 1);
			else idx = (j < junk_at) ? j : j - 1;
			val = (idx < NUM_PLANES) ? plane_set[idx] : {$urandom, $urandom};
			cfg_we    <= 1'b1;
			cfg_addr  <= idx[CFG_IDX_W-1:0];
			cfg_wdata <= val;
			@(posedge clk);
			sb.set_plane(idx, val);
		end
		cfg_we <= 1'b0;
		n_sets++;
	endtask

	// one command beat after a random gap; op, pos_x and size_x carry noise while start is low
	task automatic send_cmd(input cull_cmd_t c, input int max_gap);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			start  <= 1'b0;
			op     <= 2'($urandom);
			pos_x  <= COORD_BITS'($urandom);
			size_x <= SIZE_BITS'($urandom);
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		op     <= c.op;
		pos_x  <= c.px;
		pos_y  <= c.py;
		pos_z  <= c.pz;
		size_x <= c.sx;
		size_y <= c.sy;
		size_z <= c.sz;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_cmd(c);
	endtask

	task automatic send_obj(op_t o, int px, int py, int pz, int sx, int sy, int sz);
		cull_cmd_t c;
		c.op = o;
		c.px = COORD_BITS'(px);
		c.py = COORD_BITS'(py);
		c.pz = COORD_BITS'(pz);
		c.sx = SIZE_BITS'(sx);
		c.sy = SIZE_BITS'(sy);
		c.sz = SIZE_BITS'(sz);
		send_cmd(c, MAX_GAP);
	endtask

	// wait until every result is back and the pipeline is empty
	task automatic drain();
		start <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	initial begin
		int         span, n_items, max_gap, phase, n_random;
		plane_set_e kind;
		sb        = new;
		arst_n    = 1'b0;
		start     = 1'b0;
		op        = OP_POINT;
		pos_x     = '0;
		pos_y     = '0;
		pos_z     = '0;
		size_x    = '0;
		size_y    = '0;
		size_z    = '0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// planes cleared by reset: everything visible, even at the extremes
		send_obj(OP_POINT, COORD_MAX, COORD_MIN, 0, SIZE_MAX, SIZE_MAX, SIZE_MAX);
		send_obj(OP_CUBE, COORD_MIN, COORD_MAX, COORD_MAX, SIZE_MAX, 0, 0);
		send_obj(OP_SPHERE, 0, 0, 0, SIZE_MAX, 0, 0);
		send_obj(OP_BOX, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX);
		drain();

		// axis box of half side 1000: boundaries, unused sizes, corner saturation
		axis_planes(1000);
		program_planes();
		send_obj(OP_POINT, 0, 0, 0, SIZE_MAX, SIZE_MAX, SIZE_MAX);
		send_obj(OP_POINT, 1000, 0, 0, 0, 0, 0);
		send_obj(OP_POINT, 1001, 0, 0, 0, 0, 0);
		send_obj(OP_POINT, 0, 0, -1001, 0, 0, 0);
		send_obj(OP_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0);
		send_obj(OP_SPHERE, 1500, 0, 0, 500, 0, 0);
		send_obj(OP_SPHERE, 1500, 0, 0, 499, 0, 0);
		send_obj(OP_SPHERE, 1500, 0, 0, 499, SIZE_MAX, SIZE_MAX);
		send_obj(OP_SPHERE, COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, 0, 0);
		send_obj(OP_CUBE, 1500, 0, 0, 500, 0, 0);
		send_obj(OP_CUBE, 1500, 0, 0, 499, SIZE_MAX, SIZE_MAX);
		send_obj(OP_CUBE, COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, 0, 0);
		send_obj(OP_BOX, 1500, 0, 0, 500, 0, 0);
		send_obj(OP_BOX, 0, 1500, 0, 0, 499, SIZE_MAX);
		send_obj(OP_BOX, 0, 0, -1500, 0, 0, 500);
		send_obj(OP_BOX, COORD_MIN, 0, 0, SIZE_MAX, 0, 0);
		drain();

		// random phases, cycling through the plane set kinds
		phase    = 0;
		n_random = 0;
		while (n_random < N_RANDOM) begin
			kind = plane_set_e'(phase % N_SET_KINDS);
			span = build_planes(kind);
			program_planes();
			n_items = $urandom_range(40, 120);
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
			for (int i = 0; i < n_items; i++) send_cmd(gen_cmd(span), max_gap);
			n_random += n_items;
			drain();
			phase++;
		end

		$display("covered %0d commands over %0d plane sets:", sb.n_checked, n_sets,
			" %0d point, %0d cube, %0d sphere, %0d box",
			sb.n_op[0], sb.n_op[1], sb.n_op[2], sb.n_op[3]);
		$display("%0d predicted visible, %0d culled, %0d errors",
			sb.n_visible, sb.n_checked - sb.n_visible, sb.n_errors);
		if (sb.n_errors == 0 && sb.outstanding() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
